[rtl/plti_pkg.sv]
package plti_pkg;

  // Table geometry
  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int DATA_W      = 32;
  localparam int CNT_W       = 5;
  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(2);

  // Arithmetic widths: |slope| < 2^49, offset < 2^32, |slope * offset| < 2^48
  localparam int QUO_W = 49;
  localparam int DEN_W = 32;
  localparam int MAG_W = 48;
  localparam int PHI_W = MAG_W - DEN_W;
  localparam int FRAC  = 16;

  // Request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // One breakpoint as stored in the table memory
  typedef struct packed {
    logic signed [DATA_W-1:0] alt;
    logic signed [DATA_W-1:0] val;
  } plti_entry_t;

  // Divider status toward the controller
  typedef struct packed {
    logic busy;
    logic done;
  } plti_div_stat_t;

endpackage

[rtl/plti_if.sv]
// Request channel: table writes and queries
interface plti_req_if;
  import plti_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [IDX_W-1:0]         entry_index;
  logic signed [DATA_W-1:0] entry_altitude;
  logic signed [DATA_W-1:0] entry_value;
  logic signed [DATA_W-1:0] query_altitude;

  modport source (
    output valid, req_type, entry_index, entry_altitude, entry_value, query_altitude,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_index, entry_altitude, entry_value, query_altitude,
    output ready
  );
endinterface

// Result channel: one transaction per query
interface plti_res_if;
  import plti_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic                     in_segment;

  modport source (
    output valid, result_value, in_segment,
    input  ready
  );
  modport sink (
    input  valid, result_value, in_segment,
    output ready
  );
endinterface

[rtl/plti_div.sv]
// Restoring unsigned divider, one quotient bit per cycle
module plti_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [plti_pkg::QUO_W-1:0]   dividend,
  input  logic [plti_pkg::DEN_W-1:0]   divisor,
  output plti_pkg::plti_div_stat_t     stat,
  output logic [plti_pkg::QUO_W-1:0]   quotient
);
  import plti_pkg::*;

  localparam int STEP_W = $clog2(QUO_W + 1);

  logic [DEN_W-1:0]  rem;
  logic [QUO_W-1:0]  quo;
  logic [DEN_W-1:0]  den;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;

  logic [DEN_W:0]    shifted;
  logic [DEN_W+1:0]  diff;
  logic              take;

  // Trial subtraction of the divisor from the shifted remainder
  always_comb begin
    shifted = {rem, quo[QUO_W-1]};
    diff    = {1'b0, shifted} - {2'b00, den};
    take    = !diff[DEN_W+1];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(QUO_W);
      end else if (busy) begin
        step <= step - STEP_W'(1);
        if (step == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      den <= divisor;
    end else if (busy) begin
      rem <= take ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo <= {quo[QUO_W-2:0], take};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

[rtl/piecewise_linear_table_interp.sv]
// Channel   Dir  Transaction
// req       in   table write (req_type 0) or altitude query (req_type 1)
// res       out  interpolated value and in_segment flag, one per query
// cfg       in   entry_count write, taken on any cycle with cfg_we high
//
// A table write is stored when it is accepted in idle. A query reads the table one entry a cycle from
// the single memory read port until its segment is found or the last entry in use
// is read, then runs a 49-step bit-serial divide for the slope and two
// partial-product multiplies.
// Synchronous reset clears control and sets entry_count to 2; the table contents
// are undefined until written. A finished result sits in the output register
// while the next transaction is accepted; a later result waits until it is taken.
module piecewise_linear_table_interp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [plti_pkg::CNT_W-1:0] cfg_wdata,
  plti_req_if.sink                   req,
  plti_res_if.source                 res
);
  import plti_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SETUP,
    ST_DIV,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_DONE
  } state_t;

  state_t state;

  // Configuration register
  logic [CNT_W-1:0] entry_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= COUNT_RESET;
    end else if (cfg_we) begin
      entry_count <= cfg_wdata;
    end
  end

  // Breakpoint table memory, one read port with registered data
  plti_entry_t      table_mem [MAX_ENTRIES];
  plti_entry_t      rd_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[req.entry_index] <= '{alt: req.entry_altitude, val: req.entry_value};
    end
    if (rd_en) begin
      rd_data <= table_mem[rd_addr];
    end
  end

  // Query working registers
  logic signed [DATA_W-1:0] q_alt;
  logic [CNT_W-1:0]         n_eff;
  logic [IDX_W-1:0]         scan_cnt;
  plti_entry_t              prev;
  logic [DATA_W:0]          dv;
  logic [DEN_W-1:0]         dd;
  logic [DEN_W-1:0]         offs;
  logic signed [DATA_W-1:0] base;
  logic                     neg;
  logic [63:0]              p_lo;
  logic [PHI_W-1:0]         p_hi;
  logic [DATA_W-1:0]        scaled;
  logic signed [DATA_W-1:0] hold_value;
  logic                     hold_hit;

  // Handshake decode
  logic req_fire;
  logic query_fire;
  logic out_free;

  assign req.ready  = (state == ST_IDLE);
  assign req_fire   = req.valid && req.ready;
  assign query_fire = req_fire && (req.req_type == REQ_QUERY);
  assign wr_en      = req_fire && (req.req_type == REQ_WRITE) &&
                      (32'(req.entry_index) < MAX_ENTRIES);
  assign out_free   = !res.valid || res.ready;

  // Effective entry count: zero counts as one, clamp at table depth
  logic [CNT_W-1:0] n_clamped;

  always_comb begin
    if (entry_count == '0) begin
      n_clamped = CNT_W'(1);
    end else if (entry_count > CNT_W'(MAX_ENTRIES)) begin
      n_clamped = CNT_W'(MAX_ENTRIES);
    end else begin
      n_clamped = entry_count;
    end
  end

  // Segment test on the entry just read against the one before it
  logic is_last;
  logic seg_hit;

  always_comb begin
    is_last = ({1'b0, scan_cnt} == (n_eff - CNT_W'(1)));
    seg_hit = (scan_cnt != '0) && (prev.alt <= q_alt) && (q_alt < rd_data.alt);
  end

  // Table read issue
  always_comb begin
    rd_en   = query_fire || ((state == ST_SCAN) && !seg_hit && !is_last);
    rd_addr = (state == ST_SCAN) ? scan_cnt + IDX_W'(1) : '0;
  end

  // Divider hookup: |dv| * 2^16 / dd
  plti_div_stat_t   div_stat;
  logic [QUO_W-1:0] div_quo;
  logic [DATA_W:0]  dv_mag;

  assign dv_mag = dv[DATA_W] ? (~dv + (DATA_W+1)'(1)) : dv;

  plti_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_SETUP),
    .dividend ({dv_mag, {FRAC{1'b0}}}),
    .divisor  (dd),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // Product magnitude and signed, saturated sum
  logic [MAG_W-1:0]       mag;
  logic signed [DATA_W+1:0] sum;
  logic signed [DATA_W-1:0] sat_value;

  always_comb begin
    mag    = p_lo[MAG_W-1:0] + {p_hi, {DEN_W{1'b0}}};
    scaled = mag[MAG_W-1:FRAC];
    if (neg) begin
      sum = {{2{base[DATA_W-1]}}, base} - {2'b00, scaled};
    end else begin
      sum = {{2{base[DATA_W-1]}}, base} + {2'b00, scaled};
    end
    if (sum[DATA_W+1:DATA_W-1] == 3'b000 || sum[DATA_W+1:DATA_W-1] == 3'b111) begin
      sat_value = sum[DATA_W-1:0];
    end else if (sum[DATA_W+1]) begin
      sat_value = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  // Controller with result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res.valid <= 1'b0;
    end else begin
      // A result loaded in DONE takes the place of one being taken
      if (res.valid && res.ready && (state != ST_DONE)) begin
        res.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (query_fire) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (seg_hit) begin
            state <= ST_SETUP;
          end else if (is_last) begin
            state <= ST_DONE;
          end
        end
        ST_SETUP: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state <= ST_MUL_LO;
          end
        end
        ST_MUL_LO: begin
          state <= ST_MUL_HI;
        end
        ST_MUL_HI: begin
          state <= ST_SUM;
        end
        ST_SUM: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            res.valid        <= 1'b1;
            res.result_value <= hold_value;
            res.in_segment   <= hold_hit;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Query datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        q_alt    <= req.query_altitude;
        n_eff    <= n_clamped;
        scan_cnt <= '0;
      end
      ST_SCAN: begin
        if (seg_hit) begin
          dv   <= {rd_data.val[DATA_W-1], rd_data.val} - {prev.val[DATA_W-1], prev.val};
          dd   <= DEN_W'(rd_data.alt - prev.alt);
          offs <= DEN_W'(q_alt - prev.alt);
          base <= prev.val;
        end else if (is_last) begin
          hold_value <= rd_data.val;
          hold_hit   <= 1'b0;
        end else begin
          prev     <= rd_data;
          scan_cnt <= scan_cnt + IDX_W'(1);
        end
      end
      ST_SETUP: begin
        neg <= dv[DATA_W];
      end
      ST_MUL_LO: begin
        p_lo <= div_quo[DEN_W-1:0] * offs;
      end
      ST_MUL_HI: begin
        p_hi <= PHI_W'(div_quo[QUO_W-1:DEN_W] * offs);
      end
      ST_SUM: begin
        hold_value <= sat_value;
        hold_hit   <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Checks
  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_DIV))
    else $error("divider finished outside the divide state");

  a_div_running: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("waiting on an idle divider");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> ({1'b0, scan_cnt} < n_eff))
    else $error("table scan ran past the entries in use");

  a_write_no_scan: assert property (@(posedge clk) disable iff (rst)
    (req_fire && (req.req_type == REQ_WRITE)) |=> (state == ST_IDLE))
    else $error("table write started a query");

endmodule
